// ===== rtl/cda_pkg.sv =====
package cda_pkg;

   localparam int unsigned NumerWidth = 32;
   localparam int unsigned DivCells = 32;

   localparam logic [15:0] Sign16 = 16'h8000;
   localparam logic [15:0] All16 = 16'hffff;

   localparam int unsigned FlagC = 0;
   localparam int unsigned FlagV = 1;
   localparam int unsigned FlagZ = 2;
   localparam int unsigned FlagN = 3;

   typedef enum logic [3:0] {
      FUNC_ADD  = 4'd0,
      FUNC_ADC  = 4'd1,
      FUNC_SUB  = 4'd2,
      FUNC_SBC  = 4'd3,
      FUNC_IDIV = 4'd4,
      FUNC_FDIV = 4'd5,
      FUNC_LSRD = 4'd6,
      FUNC_ASLD = 4'd7,
      FUNC_MUL  = 4'd8,
      FUNC_BSET = 4'd9,
      FUNC_BCLR = 4'd10,
      FUNC_LOAD = 4'd11
   } func_type;

   // item travelling down the divider chain
   typedef struct packed {
      logic        valid;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [15:0] main_result;
      logic [7:0]  flags_pre;
      logic        is_div;
      logic [31:0] numer;
      logic [15:0] rem;
      logic [15:0] quot;
   } cell_type;

endpackage

// ===== rtl/cda_cell.sv =====
module cda_cell #(
   parameter int unsigned Index = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  cda_pkg::cell_type cell_i,
   output cda_pkg::cell_type cell_o
);

   cda_pkg::cell_type cell_ff, cell_in;
   logic [17:0] trial;
   logic [16:0] shifted;

   always_comb begin
      cell_in = cell_i;
      shifted = {cell_i.rem, cell_i.numer[cda_pkg::NumerWidth - 1 - Index]};
      trial = {1'b0, shifted} - {2'b00, cell_i.operand_b};
      cell_in.quot = {cell_i.quot[14:0], 1'b0};
      if (!trial[17]) begin
         cell_in.rem = trial[15:0];
         cell_in.quot[0] = 1'b1;
      end else begin
         cell_in.rem = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (enable) begin
         cell_ff.operand_a <= cell_in.operand_a;
         cell_ff.operand_b <= cell_in.operand_b;
         cell_ff.main_result <= cell_in.main_result;
         cell_ff.flags_pre <= cell_in.flags_pre;
         cell_ff.is_div <= cell_in.is_div;
         cell_ff.numer <= cell_in.numer;
         cell_ff.rem <= cell_in.rem;
         cell_ff.quot <= cell_in.quot;
      end
   end

   assign cell_o = cell_ff;

endmodule

// ===== rtl/cda_front.sv =====
module cda_front (
   input  logic [3:0]        func,
   input  logic [15:0]       operand_a,
   input  logic [15:0]       operand_b,
   input  logic [7:0]        flags_in,
   input  logic              valid,
   output cda_pkg::cell_type cell_o
);

   logic [16:0] sum;
   logic [15:0] r;
   logic [7:0]  f;
   logic [7:0]  bits;
   logic [15:0] prod;
   logic        cin;

   always_comb begin
      cin = flags_in[cda_pkg::FlagC];
      r = operand_a;
      f = flags_in;
      sum = '0;
      bits = '0;
      prod = operand_a[15:8] * operand_a[7:0];
      case (func)
         cda_pkg::FUNC_ADD, cda_pkg::FUNC_ADC: begin
            sum = {1'b0, operand_a} + {1'b0, operand_b}
               + {16'd0, (func == cda_pkg::FUNC_ADC) & cin};
            r = sum[15:0];
            f[cda_pkg::FlagC] = sum[16];
            f[cda_pkg::FlagV] = (operand_a[15] & operand_b[15] & ~r[15])
               | (~operand_a[15] & ~operand_b[15] & r[15]);
            f[cda_pkg::FlagZ] = (r == 16'd0);
            f[cda_pkg::FlagN] = r[15];
         end
         cda_pkg::FUNC_SUB, cda_pkg::FUNC_SBC: begin
            sum = {1'b0, operand_a} - {1'b0, operand_b}
               - {16'd0, (func == cda_pkg::FUNC_SBC) & cin};
            r = sum[15:0];
            f[cda_pkg::FlagC] = sum[16];
            f[cda_pkg::FlagV] = (operand_a[15] & ~operand_b[15] & ~r[15])
               | (~operand_a[15] & operand_b[15] & r[15]);
            f[cda_pkg::FlagZ] = (r == 16'd0);
            f[cda_pkg::FlagN] = r[15];
         end
         cda_pkg::FUNC_IDIV, cda_pkg::FUNC_FDIV: begin
            f[cda_pkg::FlagV] = (func == cda_pkg::FUNC_FDIV) && (operand_b <= operand_a);
         end
         cda_pkg::FUNC_LSRD: begin
            r = {1'b0, operand_a[15:1]};
            f[cda_pkg::FlagC] = operand_a[0];
            f[cda_pkg::FlagV] = operand_a[0];
            f[cda_pkg::FlagZ] = (r == 16'd0);
            f[cda_pkg::FlagN] = 1'b0;
         end
         cda_pkg::FUNC_ASLD: begin
            r = {operand_a[14:0], 1'b0};
            f[cda_pkg::FlagC] = operand_a[15];
            f[cda_pkg::FlagN] = r[15];
            f[cda_pkg::FlagZ] = (r == 16'd0);
            f[cda_pkg::FlagV] = r[15] ^ operand_a[15];
         end
         cda_pkg::FUNC_MUL: begin
            r = prod;
            f[cda_pkg::FlagC] = prod[7];
         end
         cda_pkg::FUNC_BSET, cda_pkg::FUNC_BCLR: begin
            bits = (func == cda_pkg::FUNC_BSET) ? (operand_a[7:0] | operand_b[7:0])
               : (operand_a[7:0] & ~operand_b[7:0]);
            r = {8'd0, bits};
            f[cda_pkg::FlagV] = 1'b0;
            f[cda_pkg::FlagZ] = (bits == 8'd0);
            f[cda_pkg::FlagN] = bits[7];
         end
         cda_pkg::FUNC_LOAD: begin
            r = operand_b;
            f[cda_pkg::FlagV] = 1'b0;
            f[cda_pkg::FlagZ] = (operand_b == 16'd0);
            f[cda_pkg::FlagN] = operand_b[15];
         end
         default: begin
            r = operand_a;
         end
      endcase
      cell_o.valid = valid;
      cell_o.operand_a = operand_a;
      cell_o.operand_b = operand_b;
      cell_o.main_result = r;
      cell_o.flags_pre = f;
      cell_o.is_div = (func == cda_pkg::FUNC_IDIV) || (func == cda_pkg::FUNC_FDIV);
      cell_o.numer = (func == cda_pkg::FUNC_FDIV) ? {operand_a, 16'd0} : {16'd0, operand_a};
      cell_o.rem = '0;
      cell_o.quot = '0;
   end

endmodule

// ===== rtl/cpu_double_accumulator_alu_core.sv =====
// input to result: 32 divider cells then the output register, one cell per quotient bit
// throughput: one item per cycle while not stalled; the 32-cell divider chain advances
// whenever the output register is free or being emptied
// reset: synchronous active high, clears all stage valid bits and the output valid bit
module cpu_double_accumulator_alu_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_func,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic [7:0]  req_flags_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_main_result,
   output logic [15:0] rsp_second_result,
   output logic [7:0]  rsp_flags_out
);

   cda_pkg::cell_type chain [cda_pkg::DivCells + 1];
   logic        advance;
   logic        out_valid_ff;
   logic [15:0] out_main_ff, out_second_ff;
   logic [7:0]  out_flags_ff;
   logic [15:0] fin_main, fin_second;
   logic [7:0]  fin_flags;
   cda_pkg::cell_type tail;

   assign advance = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   cda_front u_front (
      .func      (req_func),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .flags_in  (req_flags_in),
      .valid     (req_valid),
      .cell_o    (chain[0])
   );

   for (genvar i = 0; i < cda_pkg::DivCells; i++) begin : g_cell
      cda_cell #(.Index(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .cell_i (chain[i]),
         .cell_o (chain[i + 1])
      );
   end

   assign tail = chain[cda_pkg::DivCells];

   always_comb begin
      fin_main = tail.main_result;
      fin_second = tail.operand_b;
      fin_flags = tail.flags_pre;
      if (tail.is_div) begin
         if (tail.operand_b == 16'd0) begin
            fin_second = cda_pkg::All16;
            fin_main = tail.operand_a;
            fin_flags[cda_pkg::FlagC] = 1'b1;
         end else begin
            fin_second = tail.quot;
            fin_main = tail.rem;
            fin_flags[cda_pkg::FlagC] = 1'b0;
         end
         fin_flags[cda_pkg::FlagZ] = (fin_second == 16'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= tail.valid;
      end
      if (advance) begin
         out_main_ff <= fin_main;
         out_second_ff <= fin_second;
         out_flags_ff <= fin_flags;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_main_result = out_main_ff;
   assign rsp_second_result = out_second_ff;
   assign rsp_flags_out = out_flags_ff;

`ifndef SYNTHESIS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_main_result)
      && $stable(rsp_second_result) && $stable(rsp_flags_out))
      else $error("stalled result changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;

   localparam int unsigned NumRandom = 950;
   localparam int unsigned WatchdogLimit = 20000;
   localparam logic [7:0] MaskC = 8'h01;
   localparam logic [7:0] MaskV = 8'h02;
   localparam logic [7:0] MaskZ = 8'h04;
   localparam logic [7:0] MaskN = 8'h08;

   typedef struct {
      logic [3:0]  func;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [7:0]  flags_in;
   } alu_op_type;

   typedef struct {
      logic [15:0] main_result;
      logic [15:0] second_result;
      logic [7:0]  flags_out;
   } alu_res_type;

   typedef struct {
      alu_op_type  op;
      logic        typed;
      alu_res_type res;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_func;
   logic [15:0] req_operand_a;
   logic [15:0] req_operand_b;
   logic [7:0]  req_flags_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_main_result;
   logic [15:0] rsp_second_result;
   logic [7:0]  rsp_flags_out;

   alu_res_type pending_results[$];
   int unsigned mismatches;
   int unsigned idle_cycles;
   bit          sending_done;
   bit          hold_off_done;

   cpu_double_accumulator_alu_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .req_flags_in(req_flags_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_main_result(rsp_main_result),
      .rsp_second_result(rsp_second_result),
      .rsp_flags_out(rsp_flags_out)
   );

   function automatic logic [7:0] set_nz16(logic [7:0] f, logic [15:0] r);
      if (r == 16'h0000) f |= MaskZ;
      if (r[15]) f |= MaskN;
      return f;
   endfunction

   function automatic alu_res_type execute_op(alu_op_type op);
      alu_res_type res;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] r;
      logic [7:0]  f;
      logic [7:0]  byte_r;
      logic [31:0] numer;
      logic [31:0] quot;
      logic        carry_in;
      a = op.operand_a;
      b = op.operand_b;
      f = op.flags_in;
      carry_in = op.flags_in[cda_pkg::FlagC];
      res.main_result = a;
      res.second_result = b;
      res.flags_out = f;
      case (op.func)
         cda_pkg::FUNC_ADD, cda_pkg::FUNC_ADC: begin
            r = a + b + ((op.func == cda_pkg::FUNC_ADC) ? {15'd0, carry_in} : 16'd0);
            f = set_nz16(f & ~(MaskN | MaskZ | MaskV | MaskC), r);
            if ((a[15] & b[15]) | (b[15] & ~r[15]) | (~r[15] & a[15])) f |= MaskC;
            if ((a[15] & b[15] & ~r[15]) | (~a[15] & ~b[15] & r[15])) f |= MaskV;
            res.main_result = r;
         end
         cda_pkg::FUNC_SUB, cda_pkg::FUNC_SBC: begin
            r = a - b - ((op.func == cda_pkg::FUNC_SBC) ? {15'd0, carry_in} : 16'd0);
            f = set_nz16(f & ~(MaskN | MaskZ | MaskV | MaskC), r);
            if ((~a[15] & b[15]) | (b[15] & r[15]) | (r[15] & ~a[15])) f |= MaskC;
            if ((a[15] & ~b[15] & ~r[15]) | (~a[15] & b[15] & r[15])) f |= MaskV;
            res.main_result = r;
         end
         cda_pkg::FUNC_IDIV, cda_pkg::FUNC_FDIV: begin
            numer = (op.func == cda_pkg::FUNC_FDIV) ? {a, 16'h0000} : {16'h0000, a};
            f = f & ~(MaskZ | MaskV | MaskC);
            if (op.func == cda_pkg::FUNC_FDIV && b <= a) f |= MaskV;
            if (b == 16'h0000) begin
               res.second_result = cda_pkg::All16;
               f |= MaskC;
            end else begin
               quot = numer / {16'h0000, b};
               res.second_result = quot[15:0];
               res.main_result = 16'(numer % {16'h0000, b});
            end
            if (res.second_result == 16'h0000) f |= MaskZ;
         end
         cda_pkg::FUNC_LSRD: begin
            r = a >> 1;
            f = f & ~(MaskN | MaskZ | MaskV | MaskC);
            if (r == 16'h0000) f |= MaskZ;
            if (a[0]) f |= MaskC | MaskV;
            res.main_result = r;
         end
         cda_pkg::FUNC_ASLD: begin
            r = a << 1;
            f = set_nz16(f & ~(MaskN | MaskZ | MaskV | MaskC), r);
            if (a[15]) f |= MaskC;
            if (f[cda_pkg::FlagN] != f[cda_pkg::FlagC]) f |= MaskV;
            res.main_result = r;
         end
         cda_pkg::FUNC_MUL: begin
            r = a[15:8] * a[7:0];
            f = f & ~MaskC;
            if (r[7]) f |= MaskC;
            res.main_result = r;
         end
         cda_pkg::FUNC_BSET, cda_pkg::FUNC_BCLR: begin
            byte_r = (op.func == cda_pkg::FUNC_BSET) ? (a[7:0] | b[7:0])
                                                     : (a[7:0] & ~b[7:0]);
            f = f & ~(MaskN | MaskZ | MaskV);
            if (byte_r == 8'h00) f |= MaskZ;
            if (byte_r[7]) f |= MaskN;
            res.main_result = {8'h00, byte_r};
         end
         cda_pkg::FUNC_LOAD: begin
            f = set_nz16(f & ~(MaskN | MaskZ | MaskV), b);
            res.main_result = b;
         end
         default: ;
      endcase
      res.flags_out = f;
      return res;
   endfunction

   function automatic logic [15:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return cda_pkg::All16;
         2: return cda_pkg::Sign16;
         3: return 16'(cda_pkg::Sign16 - 1);
         4: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic row_type mk(logic [3:0] fn, logic [15:0] a, logic [15:0] b,
                                  logic [7:0] fi, logic typed = 1'b0,
                                  logic [15:0] mr = 16'h0, logic [15:0] sr = 16'h0,
                                  logic [7:0] fo = 8'h0);
      row_type row;
      row.op.func = fn;
      row.op.operand_a = a;
      row.op.operand_b = b;
      row.op.flags_in = fi;
      row.typed = typed;
      row.res.main_result = mr;
      row.res.second_result = sr;
      row.res.flags_out = fo;
      return row;
   endfunction

   task automatic send_op(alu_op_type op, alu_res_type res);
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
            @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= op.func;
      req_operand_a <= op.operand_a;
      req_operand_b <= op.operand_b;
      req_flags_in <= op.flags_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(res);
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stimulus
   initial begin
      row_type    rows[$];
      alu_op_type op;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = cda_pkg::FUNC_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      req_flags_in = '0;
      sending_done = 1'b0;
      rows.push_back(mk(cda_pkg::FUNC_ADD, cda_pkg::All16, 16'h0001, 8'h00, 1'b1,
                        16'h0000, 16'h0001, 8'h05));
      rows.push_back(mk(cda_pkg::FUNC_ADD, 16'h7fff, 16'h0001, 8'hf0, 1'b1,
                        cda_pkg::Sign16, 16'h0001, 8'hfa));
      rows.push_back(mk(cda_pkg::FUNC_ADC, cda_pkg::All16, cda_pkg::All16, 8'h01));
      rows.push_back(mk(cda_pkg::FUNC_SUB, 16'h0000, 16'h0001, 8'h00, 1'b1,
                        cda_pkg::All16, 16'h0001, 8'h09));
      rows.push_back(mk(cda_pkg::FUNC_SBC, cda_pkg::Sign16, 16'h0000, 8'hff));
      rows.push_back(mk(cda_pkg::FUNC_IDIV, 16'h1234, 16'h0000, 8'h00, 1'b1,
                        16'h1234, cda_pkg::All16, 8'h01));
      rows.push_back(mk(cda_pkg::FUNC_FDIV, 16'h0000, 16'h0000, 8'hff, 1'b1,
                        16'h0000, cda_pkg::All16, 8'hfb));
      rows.push_back(mk(cda_pkg::FUNC_IDIV, cda_pkg::All16, 16'h0001, 8'h00));
      rows.push_back(mk(cda_pkg::FUNC_IDIV, 16'h0003, cda_pkg::All16, 8'h00));
      rows.push_back(mk(cda_pkg::FUNC_FDIV, 16'h0001, 16'h0003, 8'h00));
      rows.push_back(mk(cda_pkg::FUNC_FDIV, cda_pkg::All16, 16'h0001, 8'h00));
      rows.push_back(mk(cda_pkg::FUNC_FDIV, 16'h0002, 16'h0002, 8'h00));
      rows.push_back(mk(cda_pkg::FUNC_LSRD, 16'h0001, 16'h0000, 8'h00, 1'b1,
                        16'h0000, 16'h0000, 8'h07));
      rows.push_back(mk(cda_pkg::FUNC_ASLD, cda_pkg::Sign16, cda_pkg::All16, 8'h00, 1'b1,
                        16'h0000, cda_pkg::All16, 8'h07));
      rows.push_back(mk(cda_pkg::FUNC_ASLD, 16'h4000, 16'h0000, 8'h00));
      rows.push_back(mk(cda_pkg::FUNC_MUL, cda_pkg::All16, 16'h0000, 8'h00, 1'b1,
                        16'hfe01, 16'h0000, 8'h00));
      rows.push_back(mk(cda_pkg::FUNC_MUL, 16'h0000, 16'h0000, 8'hff));
      rows.push_back(mk(cda_pkg::FUNC_BSET, 16'hff00, 16'h0080, 8'h02, 1'b1,
                        16'h0080, 16'h0080, 8'h08));
      rows.push_back(mk(cda_pkg::FUNC_BCLR, 16'h00ff, 16'hffff, 8'h0a, 1'b1,
                        16'h0000, cda_pkg::All16, 8'h04));
      rows.push_back(mk(cda_pkg::FUNC_LOAD, 16'h1111, cda_pkg::Sign16, 8'h03, 1'b1,
                        cda_pkg::Sign16, cda_pkg::Sign16, 8'h09));
      rows.push_back(mk(cda_pkg::FUNC_LOAD, 16'h1111, 16'h0000, 8'h00));
      rows.push_back(mk(4'd12, cda_pkg::All16, 16'h5a5a, 8'hff, 1'b1,
                        cda_pkg::All16, 16'h5a5a, 8'hff));
      rows.push_back(mk(4'd15, 16'h0000, cda_pkg::All16, 8'h00, 1'b1,
                        16'h0000, cda_pkg::All16, 8'h00));
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[i])
         send_op(rows[i].op, rows[i].typed ? rows[i].res : execute_op(rows[i].op));
      for (int unsigned n = 0; n < NumRandom; n++) begin
         op.func = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                                 : 4'($urandom_range(0, 11));
         op.operand_a = random_operand();
         op.operand_b = random_operand();
         op.flags_in = 8'($urandom);
         send_op(op, execute_op(op));
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver, with one long hold-off to back the block up
   initial begin
      rsp_ready = 1'b0;
      hold_off_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_off_done && pending_results.size() > 10) begin
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_off_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
               @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // result check
   always @(posedge clock) begin
      alu_res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer at %0t", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (rsp_main_result !== want.main_result
                  || rsp_second_result !== want.second_result
                  || rsp_flags_out !== want.flags_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want %h %h %h got %h %h %h", want.main_result,
                     want.second_result, want.flags_out, rsp_main_result,
                     rsp_second_result, rsp_flags_out);
            end
         end
      end
   end

   // watchdog and end of run
   initial begin
      mismatches = 0;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("tb: done, errors");
            $finish;
         end
         if (sending_done && pending_results.size() == 0) begin
            repeat (40) @(posedge clock);
            if (mismatches == 0 && pending_results.size() == 0 && !rsp_valid) begin
               $display("tb: done, clean");
            end else begin
               $display("tb: done, errors");
            end
            $finish;
         end
      end
   end

endmodule

// ===== cpu_double_accumulator_alu_core.f =====
rtl/cda_pkg.sv
rtl/cda_cell.sv
rtl/cda_front.sv
rtl/cpu_double_accumulator_alu_core.sv
dv/tb.sv
